// ===== sv/wdpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Watchdog prescale/reload fit package
// Shared widths, limits, the candidate record and the fit and select
// functions that the pipeline uses.
// ----------------------------------------------------------------------------
`default_nettype none

package wdpr_pkg;

    localparam int TIMEOUT_W   = 20;
    localparam int CODE_W      = 3;
    localparam int RELOAD_W    = 12;
    localparam int CODE_COUNT  = 7;
    localparam int TICK_LIMIT  = 4096;
    localparam int TICK_W      = TIMEOUT_W + 3;
    localparam int GOT_W       = TICK_W + CODE_COUNT - 1;

    localparam logic [CODE_W-1:0]   CODE_MAX   = CODE_W'(CODE_COUNT - 1);
    localparam logic [RELOAD_W-1:0] RELOAD_MAX = {RELOAD_W{1'b1}};

    typedef struct packed {
        logic                 ok;
        logic [TIMEOUT_W-1:0] err;
        logic [CODE_W-1:0]    code;
        logic [RELOAD_W-1:0]  reload;
    } cand_t;

    function automatic cand_t fit_code(input logic [TIMEOUT_W-1:0] t,
                                       input logic [CODE_W-1:0] code);
        logic [TICK_W-1:0] ticks;
        logic [TICK_W-1:0] reload_full;
        logic [GOT_W-1:0]  got;
        logic [GOT_W-1:0]  tw;
        logic [GOT_W-1:0]  err;
        cand_t             r;
        ticks = {t, 3'b000} >> code;
        if (ticks == '0)
        begin
            ticks = TICK_W'(1);
        end
        got = ({{(GOT_W - TICK_W){1'b0}}, ticks} << code) >> 3;
        tw  = {{(GOT_W - TIMEOUT_W){1'b0}}, t};
        err = (got > tw) ? (got - tw) : (tw - got);
        reload_full = ticks - TICK_W'(1);
        r.ok     = (ticks <= TICK_W'(TICK_LIMIT));
        r.err    = err[TIMEOUT_W-1:0];
        r.code   = code;
        r.reload = reload_full[RELOAD_W-1:0];
        return r;
    endfunction

    // The lower code sits in a; an ok b replaces it if a is not ok or on a strictly smaller error.
    function automatic cand_t pick(input cand_t a, input cand_t b);
        cand_t r;
        r = a;
        if (b.ok && (!a.ok || (b.err < a.err)))
        begin
            r = b;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/watchdog_prescale_reload_fit.sv =====
// ----------------------------------------------------------------------------
// Watchdog prescale/reload fit
// Picks the prescaler code and reload count whose watchdog timeout on a
// 32 kHz tick comes closest to a requested timeout in milliseconds.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ------------------------------
//  in       in_valid / in_stall  target_ms
//  out      out_valid/out_stall  prescaler_code, reload_value
//
//  A transaction can enter every cycle while the output is not stalled, and
//  its result passes through one input stage, one stage that fits all seven
//  codes, and three stages of a select tree. Reset clears the valid bits of
//  every stage. A stall on the output holds the whole pipeline, and in_stall
//  follows it while the output register is full.
//
`default_nettype none

module watchdog_prescale_reload_fit
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [wdpr_pkg::TIMEOUT_W-1:0] target_ms,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [wdpr_pkg::CODE_W-1:0]        prescaler_code,
    output logic [wdpr_pkg::RELOAD_W-1:0]      reload_value
);

    import wdpr_pkg::*;

    logic                 advance;
    logic                 a_valid_reg;
    logic                 b_valid_reg;
    logic                 c_valid_reg;
    logic                 d_valid_reg;
    logic                 e_valid_reg;
    logic [TIMEOUT_W-1:0] t_reg;
    cand_t                cand_reg [CODE_COUNT];
    cand_t                cand_next [CODE_COUNT];
    cand_t                w1_reg [4];
    cand_t                w1_next [4];
    cand_t                w2_reg [2];
    cand_t                w2_next [2];
    cand_t                best_next;
    logic [CODE_W-1:0]    code_reg;
    logic [CODE_W-1:0]    code_next;
    logic [RELOAD_W-1:0]  reload_reg;
    logic [RELOAD_W-1:0]  reload_next;

    assign advance        = !e_valid_reg || !out_stall;
    assign in_stall       = !advance;
    assign out_valid      = e_valid_reg;
    assign prescaler_code = code_reg;
    assign reload_value   = reload_reg;

    always_comb
    begin
        for (int i = 0; i < CODE_COUNT; i++)
        begin
            cand_next[i] = fit_code(t_reg, CODE_W'(i));
        end
        w1_next[0] = pick(cand_reg[0], cand_reg[1]);
        w1_next[1] = pick(cand_reg[2], cand_reg[3]);
        w1_next[2] = pick(cand_reg[4], cand_reg[5]);
        w1_next[3] = cand_reg[6];
        w2_next[0] = pick(w1_reg[0], w1_reg[1]);
        w2_next[1] = pick(w1_reg[2], w1_reg[3]);
        best_next  = pick(w2_reg[0], w2_reg[1]);
        if (best_next.ok)
        begin
            code_next   = best_next.code;
            reload_next = best_next.reload;
        end
        else
        begin
            code_next   = CODE_MAX;
            reload_next = RELOAD_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t_reg      <= target_ms;
            cand_reg   <= cand_next;
            w1_reg     <= w1_next;
            w2_reg     <= w2_next;
            code_reg   <= code_next;
            reload_reg <= reload_next;
        end
    end

endmodule

`default_nettype wire

// ===== test/watchdog_prescale_reload_fit_test.sv =====
// ----------------------------------------------------------------------------
// Watchdog prescale/reload fit testbench
// Sends requested timeouts through the valid/stall input channel and checks
// each prescaler code and reload count against a predictor of the closest
// fit. Both sides idle at random, and the run covers corner requests,
// back-to-back bursts, a long output hold and a full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module watchdog_prescale_reload_fit_test;

    import wdpr_pkg::*;

    localparam int          MAX_GAP      = 17;
    localparam int          REPORT_LIMIT = 10;
    localparam int          RESET_CYCLES = 11;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          HOLD_CYCLES  = 150;
    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          BLOCK_COUNT  = 12;
    localparam int          BLOCK_ITEMS  = 100;
    localparam int          BURST_ITEMS  = 40;
    localparam logic [31:0] MS_TICKS     = 32'd32;
    localparam logic [31:0] BASE_DIVIDER = 32'd4;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout;
        logic [CODE_W-1:0]    code;
        logic [RELOAD_W-1:0]  reload;
    } fit_t;

    class fit_scoreboard;
        fit_t expected_fits[$];
        int   mismatches;

        function new();
            mismatches = 0;
        endfunction

        function fit_t best_fit(input logic [TIMEOUT_W-1:0] t);
            logic [31:0] request;
            logic [31:0] divider;
            logic [31:0] ticks;
            logic [31:0] achieved;
            logic [31:0] miss;
            logic [31:0] best_miss;
            int          code;
            fit_t        fit;
            request     = 32'(t);
            fit.timeout = t;
            fit.code    = CODE_MAX;
            fit.reload  = RELOAD_MAX;
            best_miss   = '1;
            for (code = 0; code < CODE_COUNT; code++)
            begin
                divider = BASE_DIVIDER << code;
                ticks   = (request * MS_TICKS) / divider;
                if (ticks == 32'd0)
                begin
                    ticks = 32'd1;
                end
                if (ticks <= 32'(TICK_LIMIT))
                begin
                    achieved = (ticks * divider) / MS_TICKS;
                    miss = (achieved > request) ? achieved - request : request - achieved;
                    if (miss < best_miss)
                    begin
                        best_miss  = miss;
                        fit.code   = CODE_W'(code);
                        fit.reload = RELOAD_W'(ticks - 32'd1);
                    end
                end
            end
            return fit;
        endfunction

        function void note_request(input logic [TIMEOUT_W-1:0] t);
            expected_fits.push_back(best_fit(t));
        endfunction

        function void check_result(input logic [CODE_W-1:0] code,
                                   input logic [RELOAD_W-1:0] reload);
            fit_t exp_fit;
            if (expected_fits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("Unexpected result: code %0d reload %0d", code, reload);
                end
            end
            else
            begin
                exp_fit = expected_fits.pop_front();
                if (exp_fit.code !== code || exp_fit.reload !== reload)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display({"Mismatch for %0d ms: expected code %0d reload %0d,",
                                  " got code %0d reload %0d"},
                                 exp_fit.timeout, exp_fit.code, exp_fit.reload,
                                 code, reload);
                    end
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [TIMEOUT_W-1:0] target_ms;
    logic                 out_valid;
    logic                 out_stall;
    logic [CODE_W-1:0]    prescaler_code;
    logic [RELOAD_W-1:0]  reload_value;

    fit_scoreboard sb = new();
    bit            tx_burst;
    bit            rx_burst;
    int            hold_off_cycles;
    int            cycle_count = 0;

    int unsigned corner_requests[$] = '{0, 1, 2, 3, 7, 10, 512, 513, 1000, 1024, 1025,
                                        4095, 4096, 8191, 16383, 16384, 32767, 32768,
                                        32775, 32776, 32777, 100000, 524288, 1048575};

    watchdog_prescale_reload_fit dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .target_ms      (target_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .prescaler_code (prescaler_code),
        .reload_value   (reload_value)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [TIMEOUT_W-1:0] random_request();
        int unsigned pick_kind;
        int unsigned base;
        pick_kind = $urandom_range(0, 9);
        if (pick_kind <= 5)
        begin
            return TIMEOUT_W'($urandom_range(0, 32775));
        end
        else if (pick_kind <= 7)
        begin
            return TIMEOUT_W'($urandom_range(0, 1100));
        end
        else if (pick_kind == 8)
        begin
            base = 32'd512 << $urandom_range(0, CODE_COUNT - 1);
            return TIMEOUT_W'(base + $urandom_range(0, 16) - 8);
        end
        return TIMEOUT_W'($urandom_range(0, (1 << TIMEOUT_W) - 1));
    endfunction

    task automatic send_request(input logic [TIMEOUT_W-1:0] t);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        target_ms = t;
        do @(posedge clk); while (in_stall);
        sb.note_request(t);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.expected_fits.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin : receiver
        int n;
        bit hold_used;
        hold_used = 1'b0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0 && !hold_used)
            begin
                n = hold_off_cycles;
                hold_used = 1'b1;
            end
            else
            begin
                n = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (n > 0)
            begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
            sb.check_result(prescaler_code, reload_value);
        end
    end

    initial
    begin : stimulus
        int blk;
        int i;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        target_ms       = '0;
        tx_burst        = 1'b0;
        rx_burst        = 1'b0;
        hold_off_cycles = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (corner_requests[k])
        begin
            send_request(TIMEOUT_W'(corner_requests[k]));
        end

        // The sender waits for every result, then floods the block while the
        // receiver holds off, so the pipeline fills and stalls its input.
        wait_drained();
        hold_off_cycles = HOLD_CYCLES;
        tx_burst = 1'b1;
        for (i = 0; i < BURST_ITEMS; i++)
        begin
            send_request(random_request());
        end

        for (blk = 0; blk < BLOCK_COUNT; blk++)
        begin
            tx_burst = (blk % 4 == 1) || (blk % 4 == 3);
            rx_burst = (blk % 4 == 2) || (blk % 4 == 3);
            for (i = 0; i < BLOCK_ITEMS; i++)
            begin
                send_request(random_request());
            end
            if (blk == 5)
            begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_fits.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
